FILE: src/drbc_pkg.sv
// Shared types and constants for the relaxed DKIM body canonicalizer.
`timescale 1ns / 1ps

package drbc_pkg;

    // Width of the held line-break counter; the count saturates at all ones,
    // capped at the 16-bit breaks_before field.
    localparam int BREAK_COUNT_BITS = 16;
    localparam int CNT_W            = (BREAK_COUNT_BITS < 16) ? BREAK_COUNT_BITS : 16;

    // Queue between front and back
    localparam int Q_PTR_W = 1;
    localparam int Q_DEPTH = 1 << Q_PTR_W;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_BREAK,
        KIND_SPACE,
        KIND_BYTE
    } t_kind;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       end_of_body;
    } t_in_item;

    typedef struct packed {
        logic [15:0] breaks_before;
        logic        space_before;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        final_crlf;
        logic        count_saturated;
    } t_out_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] body_byte;
        logic       last;
    } t_cls_item;

endpackage

FILE: src/drbc_front.sv
// Front stage: accepts raw body bytes and classifies them.
`timescale 1ns / 1ps

module drbc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  drbc_pkg::t_in_item i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output drbc_pkg::t_cls_item o_item
);
    import drbc_pkg::*;

    logic      r_valid;
    t_cls_item r_item;
    t_cls_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.body_byte = i_data.body_byte;
        n_item.last      = i_data.end_of_body;
        unique case (i_data.body_byte) inside
            CHAR_CR:              n_item.kind = KIND_DROP;
            CHAR_LF:              n_item.kind = KIND_BREAK;
            CHAR_SPACE, CHAR_TAB: n_item.kind = KIND_SPACE;
            default:              n_item.kind = KIND_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: src/drbc_fifo.sv
// Short queue of classified items between front and back.
`timescale 1ns / 1ps

module drbc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drbc_pkg::t_cls_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output drbc_pkg::t_cls_item o_item
);
    import drbc_pkg::*;

    t_cls_item          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: src/drbc_back.sv
// Back stage: holds break/space state and builds canonical result items.
`timescale 1ns / 1ps

module drbc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drbc_pkg::t_cls_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output drbc_pkg::t_out_item o_data
);
    import drbc_pkg::*;

    logic [CNT_W-1:0] r_breaks;
    logic [CNT_W-1:0] n_breaks;
    logic             r_space;
    logic             n_space;
    logic             r_sat;
    logic             n_sat;
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             emit;
    logic             pop;

    assign o_ready = !r_out_valid || i_ready;
    assign pop     = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign emit    = (i_item.kind == KIND_BYTE) || i_item.last;

    always_comb begin
        n_breaks = r_breaks;
        n_space  = r_space;
        n_sat    = r_sat;
        unique case (i_item.kind)
            KIND_BREAK: begin
                n_space = 1'b0;
                // counter pinned at all ones; a lost break is flagged
                if (&r_breaks) begin
                    n_sat = 1'b1;
                end else begin
                    n_breaks = r_breaks + 1'b1;
                end
            end
            KIND_SPACE: begin
                n_space = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out = '0;
        n_out.final_crlf      = i_item.last;
        n_out.count_saturated = n_sat;
        if (i_item.kind == KIND_BYTE) begin
            n_out.breaks_before = 16'(r_breaks);
            n_out.space_before  = r_space;
            n_out.out_byte      = i_item.body_byte;
            n_out.byte_valid    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breaks    <= '0;
            r_space     <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_out_valid <= emit;
                if (emit) begin
                    r_breaks <= '0;
                    r_space  <= 1'b0;
                    r_sat    <= 1'b0;
                end else begin
                    r_breaks <= n_breaks;
                    r_space  <= n_space;
                    r_sat    <= n_sat;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: src/dkim_relaxed_body_canon.sv
// Path: the classify register loads on the edge that accepts the input item, then the
// 2-entry queue, then the result register, which drives o_valid.
// Throughput: 1 byte per cycle sustained while i_ready holds high; low i_ready stalls the input.
// Reset: i_rst_n synchronous active low clears break count, pending space, saturation
// flag and all valid flags; ready to accept the first item on the cycle after reset.
`timescale 1ns / 1ps

module dkim_relaxed_body_canon (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  drbc_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output drbc_pkg::t_out_item o_data
);
    import drbc_pkg::*;

    logic      front_valid;
    logic      front_ready;
    t_cls_item front_item;
    logic      q_valid;
    logic      q_ready;
    t_cls_item q_item;

    drbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    drbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    drbc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

FILE: tb/dkim_relaxed_body_canon_tb.sv
// Self-checking testbench for the relaxed DKIM body canonicalizer.
`timescale 1ns / 1ps

module dkim_relaxed_body_canon_tb;
    import drbc_pkg::*;

    localparam logic [15:0] BRK_MAX = (CNT_W >= 16) ? 16'hFFFF : 16'((32'd1 << CNT_W) - 1);
    localparam int DRAIN_GAP      = 8;     // idle clocks waited after all expected results are seen
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_ITEMS     = 1600;
    localparam int DIR_ROWS       = 28;

    typedef struct {
        logic [7:0] raw;
        logic       eob;
        int         reps;
        bit         typed;
        t_out_item  want;
    } dir_row_t;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_data  = '0;
    logic      i_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_data;

    // predictor state
    logic [15:0] brk_held   = '0;
    logic        space_held = 1'b0;
    logic        sat_held   = 1'b0;

    t_out_item pending_canon[$];
    t_out_item head_res;
    dir_row_t  dir_rows[DIR_ROWS];
    int        mismatch_cnt = 0;
    int        results_seen = 0;
    int        snd_idle_pct = 13;
    int        rcv_idle_pct = 69;
    bit        hold_req     = 1'b0;
    int        hold_left    = 0;
    int        quiet_cycles = 0;

    dkim_relaxed_body_canon dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_out_item canon_res(input logic [15:0] brk, input logic sp,
                                            input logic [7:0] b, input logic bv,
                                            input logic fin, input logic sat);
        t_out_item r;
        r.breaks_before   = brk;
        r.space_before    = sp;
        r.out_byte        = b;
        r.byte_valid      = bv;
        r.final_crlf      = fin;
        r.count_saturated = sat;
        return r;
    endfunction

    // One body byte through the canonicalizer state; emit says whether a result comes out.
    function automatic void relax_step(input logic [7:0] b, input logic eob,
                                       output bit emit, output t_out_item res);
        bit plain;
        plain = 1'b0;
        emit  = 1'b0;
        res   = '0;
        case (b) inside
            CHAR_CR: ;  // dropped
            CHAR_LF: begin
                space_held = 1'b0;
                if (brk_held >= BRK_MAX) begin
                    brk_held = BRK_MAX;
                    sat_held = 1'b1;
                end else begin
                    brk_held = brk_held + 16'd1;
                end
            end
            CHAR_SPACE, CHAR_TAB: space_held = 1'b1;
            default: plain = 1'b1;
        endcase
        if (plain) begin
            res  = canon_res(brk_held, space_held, b, 1'b1, eob, sat_held);
            emit = 1'b1;
        end else if (eob) begin
            res  = canon_res(16'd0, 1'b0, 8'd0, 1'b0, 1'b1, sat_held);
            emit = 1'b1;
        end
        if (emit) begin
            brk_held   = '0;
            space_held = 1'b0;
            sat_held   = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns, result %0d: %s", $realtime, results_seen, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string fname, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", fname, got, want));
    endtask

    // Offer one item, wait for acceptance, then record what the block should return.
    task automatic send_byte(input logic [7:0] b, input logic eob, input bit typed,
                             input t_out_item typed_res);
        bit        emit;
        t_out_item res;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{body_byte: b, end_of_body: eob};
        do @(posedge i_clk); while (!o_ready);
        relax_step(b, eob, emit, res);
        if (typed)
            pending_canon = {pending_canon, typed_res};
        else if (emit)
            pending_canon = {pending_canon, res};
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_canon.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    function automatic logic [7:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 8'($urandom_range(8'h21, 8'h7E));
        if (r < 60) return 8'($urandom_range(0, 255));
        if (r < 68) return CHAR_SPACE;
        if (r < 75) return CHAR_TAB;
        return CHAR_LF;
    endfunction

    // Mostly text lines with random content; some pure noise, some whitespace-only bodies.
    task automatic send_random_body(output int counted);
        int         len;
        int         sel;
        logic [7:0] b;
        counted = 0;
        len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 80);
        sel = $urandom_range(0, 99);
        for (int i = 0; i < len; i++) begin
            if (sel < 12) begin
                b = 8'($urandom_range(0, 255));
            end else if (sel < 22) begin
                case ($urandom_range(0, 3))
                    0: b = CHAR_CR;
                    1: b = CHAR_LF;
                    2: b = CHAR_SPACE;
                    default: b = CHAR_TAB;
                endcase
            end else begin
                b = text_byte();
                if (b == CHAR_LF && $urandom_range(0, 99) < 70)
                    send_byte(CHAR_CR, 1'b0, 1'b0, '0);
            end
            send_byte(b, i == len - 1, 1'b0, '0);
            if (b != CHAR_CR) counted++;
        end
    endtask

    // receiver: random backpressure plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 60;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_canon.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                head_res = pending_canon.pop_front();
                check_field("breaks_before", o_data.breaks_before, head_res.breaks_before);
                check_field("space_before", o_data.space_before, head_res.space_before);
                check_field("out_byte", o_data.out_byte, head_res.out_byte);
                check_field("byte_valid", o_data.byte_valid, head_res.byte_valid);
                check_field("final_crlf", o_data.final_crlf, head_res.final_crlf);
                check_field("count_saturated", o_data.count_saturated,
                            head_res.count_saturated);
            end
            results_seen++;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_canon.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int total;
        int got;
        int target;
        int last;

        dir_rows = '{
            '{8'h41,      1'b0, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h41, 1'b1, 1'b0, 1'b0)},
            '{8'h00,      1'b0, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0)},
            '{8'hFF,      1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b0)},
            '{CHAR_CR,    1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
            '{CHAR_LF,    1'b0, 3, 1'b0, '0},
            '{CHAR_SPACE, 1'b0, 1, 1'b0, '0},
            '{CHAR_TAB,   1'b0, 1, 1'b0, '0},
            '{8'h62,      1'b0, 1, 1'b0, '0},
            '{CHAR_SPACE, 1'b0, 2, 1'b0, '0},
            '{CHAR_LF,    1'b0, 1, 1'b0, '0},
            '{8'h63,      1'b0, 1, 1'b0, '0},
            '{8'h64,      1'b0, 1, 1'b0, '0},
            '{CHAR_SPACE, 1'b0, 1, 1'b0, '0},
            '{CHAR_TAB,   1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
            '{CHAR_LF,    1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
            '{CHAR_SPACE, 1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
            '{CHAR_TAB,   1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0)},
            '{CHAR_CR,    1'b0, 2, 1'b0, '0},
            '{CHAR_LF,    1'b0, 1, 1'b0, '0},
            '{8'h65,      1'b1, 1, 1'b0, '0},
            // break count right at its limit, then one and two past it
            '{CHAR_LF,    1'b0, int'(BRK_MAX), 1'b0, '0},
            '{8'h78,      1'b0, 1, 1'b1, canon_res(BRK_MAX, 1'b0, 8'h78, 1'b1, 1'b0, 1'b0)},
            '{CHAR_LF,    1'b0, int'(BRK_MAX) + 1, 1'b0, '0},
            '{CHAR_CR,    1'b1, 1, 1'b1, canon_res(16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1)},
            '{CHAR_LF,    1'b0, int'(BRK_MAX) + 2, 1'b0, '0},
            '{CHAR_SPACE, 1'b0, 1, 1'b0, '0},
            '{8'h7E,      1'b1, 1, 1'b1, canon_res(BRK_MAX, 1'b1, 8'h7E, 1'b1, 1'b1, 1'b1)},
            '{8'h7F,      1'b1, 1, 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                last = (k == dir_rows[r].reps - 1);
                send_byte(dir_rows[r].raw, dir_rows[r].eob && last,
                          dir_rows[r].typed && last, dir_rows[r].want);
            end
        end
        drain_results();

        total = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 13; rcv_idle_pct = 69; end
                1: begin snd_idle_pct = 69; rcv_idle_pct = 13; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            // long receiver hold-off while a burst of plain bytes backs up the pipeline
            hold_req = 1'b1;
            for (int k = 0; k < 30; k++)
                send_byte(8'($urandom_range(8'h21, 8'h7E)), k == 29, 1'b0, '0);
            total += 30;
            target = (phase + 1) * RAND_ITEMS / 3;
            while (total < target) begin
                send_random_body(got);
                total += got;
            end
            drain_results();
        end

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
